// ===== rtl/ppfp_pkg.sv =====
// Package for the pan position frame parser.
// Frame constants, status codes and the verdict struct; no dependencies.
`default_nettype none

package ppfp_pkg;

  localparam logic [7:0]  HEAD_BYTE   = 8'hFF;
  localparam logic [7:0]  ADDR_BYTE   = 8'h01;
  localparam logic [7:0]  PAN_REPLY   = 8'h59;
  localparam logic [15:0] ANGLE_LIMIT = 16'd36000;  // 360 degrees in hundredths
  localparam logic [3:0]  LAST_POS    = 4'd6;       // position of checksum byte
  localparam logic [3:0]  COUNT_MAX   = 4'd8;

  localparam logic [1:0] ST_ANGLE    = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_NO_ANGLE = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pan_angle;
  } verdict_t;

endpackage

`default_nettype wire

// ===== rtl/ppfp_frame_acc.sv =====
// Frame accumulator: byte position, running checksum, header check and
// captured reply bytes; forms the verdict on the frame-end beat. Uses ppfp_pkg.
`default_nettype none

module ppfp_frame_acc
  import ppfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       beat_en,
  input  wire logic [7:0] data_byte,
  input  wire logic       frame_end,
  input  wire logic       large_unit,
  output verdict_t        verdict
);

  logic [3:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic        header_bad_r, header_bad_nxt;
  logic [7:0]  command_code_r, command_code_nxt;
  logic [7:0]  angle_high_r, angle_high_nxt;
  logic [7:0]  angle_low_r, angle_low_nxt;
  logic [15:0] value;

  assign value = {angle_high_r, angle_low_r};

  // Verdict for a frame ending on this beat.
  always_comb begin
    verdict.status    = ST_REJECT;
    verdict.pan_angle = '0;
    if (byte_count_r == LAST_POS && !header_bad_r && data_byte == running_sum_r) begin
      if (command_code_r == PAN_REPLY && !large_unit && value < ANGLE_LIMIT) begin
        verdict.status    = ST_ANGLE;
        verdict.pan_angle = value;
      end else begin
        verdict.status = ST_NO_ANGLE;
      end
    end
  end

  always_comb begin
    byte_count_nxt   = byte_count_r;
    running_sum_nxt  = running_sum_r;
    header_bad_nxt   = header_bad_r;
    command_code_nxt = command_code_r;
    angle_high_nxt   = angle_high_r;
    angle_low_nxt    = angle_low_r;
    if (beat_en) begin
      if (frame_end) begin
        byte_count_nxt   = '0;
        running_sum_nxt  = '0;
        header_bad_nxt   = 1'b0;
        command_code_nxt = '0;
        angle_high_nxt   = '0;
        angle_low_nxt    = '0;
      end else begin
        if (byte_count_r == 4'd0 && data_byte != HEAD_BYTE) header_bad_nxt = 1'b1;
        if (byte_count_r == 4'd1 && data_byte != ADDR_BYTE) header_bad_nxt = 1'b1;
        if (byte_count_r >= 4'd1 && byte_count_r <= 4'd5)
          running_sum_nxt = running_sum_r + data_byte;
        if (byte_count_r == 4'd3) command_code_nxt = data_byte;
        if (byte_count_r == 4'd4) angle_high_nxt = data_byte;
        if (byte_count_r == 4'd5) angle_low_nxt = data_byte;
        if (byte_count_r < COUNT_MAX) byte_count_nxt = byte_count_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      running_sum_r  <= '0;
      header_bad_r   <= 1'b0;
      command_code_r <= '0;
      angle_high_r   <= '0;
      angle_low_r    <= '0;
    end else begin
      byte_count_r   <= byte_count_nxt;
      running_sum_r  <= running_sum_nxt;
      header_bad_r   <= header_bad_nxt;
      command_code_r <= command_code_nxt;
      angle_high_r   <= angle_high_nxt;
      angle_low_r    <= angle_low_nxt;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= COUNT_MAX)
    else $error("byte counter past saturation");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    beat_en && frame_end |=> byte_count_r == 4'd0 && running_sum_r == 8'd0 && !header_bad_r)
    else $error("frame state not cleared after frame end");

  a_header_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    header_bad_r && !(beat_en && frame_end) |=> header_bad_r)
    else $error("header error dropped inside a frame");

endmodule

`default_nettype wire

// ===== rtl/pan_position_frame_parser_core.sv =====
// Top level of the pan position frame parser: stream ports, config register
// and result register. Uses ppfp_pkg and ppfp_frame_acc.
//
// Usage:
//   in_*  : one received frame byte per beat in in_tdata, in_tlast on the
//           last byte of a packet.
//   out_* : one status beat per frame end; nothing for other bytes.
//   cfg_* : cfg_wr_en loads cfg_wr_data into large_unit (1 = large unit,
//           angle reports suppressed). Write only while idle.
// Frames of exactly 7 bytes starting FF 01 with a mod-256 checksum of
// bytes 1..5 in byte 6 are valid. A valid 0x59 reply of a small unit
// with an angle below 36000 reports the angle (status 0); other valid
// frames give status 2; anything else gives status 1.
// Timing: one byte accepted per cycle unless stalled; the status beat appears
// the cycle after the frame-end byte is accepted. The single result
// register sets the rate: in_tready is high while it is empty or being
// drained this cycle, so input keeps flowing at one beat per cycle as long
// as the receiver takes results.
// Stall: while a result waits and out_tready is low, in_tready drops and
// the result holds steady.
// Reset (rst_n low, synchronous): frame state cleared, large_unit = 0,
// no result pending.
`default_nettype none

module pan_position_frame_parser_core
  import ppfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,   // large_unit
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] data_byte
  input  wire logic        in_tlast,      // frame_end
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata      // [1:0] status, [17:2] pan_angle, [23:18] zero
);

  logic     large_unit_r;
  logic     out_valid_r, out_valid_nxt;
  verdict_t result_r;
  verdict_t verdict;
  logic     in_beat;

  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  ppfp_frame_acc u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_en    (in_beat),
    .data_byte  (in_tdata),
    .frame_end  (in_tlast),
    .large_unit (large_unit_r),
    .verdict    (verdict)
  );

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_unit_r <= 1'b0;
    end else if (cfg_wr_en) begin
      large_unit_r <= cfg_wr_data;
    end
  end

  // result register: loads on a frame-end beat, empties when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (in_beat && in_tlast) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && in_tlast) begin
      result_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, result_r.pan_angle, result_r.status};

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && result_r.status == ST_ANGLE |-> result_r.pan_angle < ANGLE_LIMIT)
    else $error("reported angle out of range");

  a_angle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && result_r.status != ST_ANGLE |-> result_r.pan_angle == 16'd0)
    else $error("angle nonzero without angle status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> result_r.status != 2'd3)
    else $error("undefined status code");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("frame end without result");

  a_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready && in_tlast) && (!out_tvalid || out_tready) |=> !out_tvalid)
    else $error("result without frame end");

endmodule

`default_nettype wire
